// ===== design/mspt_pkg.sv =====
// Shared types, codes and constants of the multi-slot periodic timer.
package mspt_pkg;

  localparam int DEF_NUM_SLOTS = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  // operation codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_ADD      = 3'd1;
  localparam logic [2:0] OP_REMOVE   = 3'd2;
  localparam logic [2:0] OP_PAUSE    = 3'd3;
  localparam logic [2:0] OP_RESUME   = 3'd4;
  localparam logic [2:0] OP_SET_IVAL = 3'd5;
  localparam logic [2:0] OP_SERVICE  = 3'd6;

  // result codes
  localparam logic [2:0] RES_DONE     = 3'd0;
  localparam logic [2:0] RES_IRQ_DUE  = 3'd1;
  localparam logic [2:0] RES_LOOP_RUN = 3'd2;
  localparam logic [2:0] RES_FULL     = 3'd3;
  localparam logic [2:0] RES_ASSIGNED = 3'd4;

  // slot kinds and run states
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_IRQ    = 2'd1;
  localparam logic [1:0] KIND_LOOP   = 2'd2;
  localparam logic [1:0] RUN_STOPPED = 2'd0;
  localparam logic [1:0] RUN_RUNNING = 2'd1;
  localparam logic [1:0] RUN_DUE     = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  slot;
    logic [31:0] interval;
    logic        kind;
    logic [31:0] tick_amount;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [2:0]  slot_out;
    logic [31:0] clock_now;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd;
    logic ev;
    logic wr;
    logic srch;
    logic svc;
    logic exec;
    logic fin;
    logic idx_inc;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       hold;
    logic       idx_last;
    logic       found;
    logic [2:0] op;
  } ctrl_sts_t;

endpackage

// ===== design/mspt_ctrl.sv =====
// Sequencer of the multi-slot periodic timer: walks the phases of each operation.
module mspt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mspt_pkg::ctrl_sts_t sts_i,
  output mspt_pkg::ctrl_cmd_t cmd_o
);
  import mspt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_SVC  = 3'd5;
  localparam logic [2:0] S_EXEC = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd      = (state_q == S_RD);
    cmd_o.ev      = (state_q == S_EV);
    cmd_o.wr      = (state_q == S_WR);
    cmd_o.srch    = (state_q == S_SRCH);
    cmd_o.svc     = (state_q == S_SVC);
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.fin     = (state_q == S_FIN);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.op) inside
            OP_TICK:    state_d = S_RD;
            OP_ADD:     state_d = S_SRCH;
            OP_SERVICE: state_d = S_SVC;
            OP_REMOVE, OP_PAUSE, OP_RESUME, OP_SET_IVAL: state_d = S_EXEC;
            default:    state_d = S_FIN;
          endcase
        end
      end
      S_RD: state_d = S_EV;
      S_EV: state_d = S_WR;
      S_WR: begin
        if (!sts_i.hold) begin
          if (sts_i.idx_last) begin
            state_d = S_FIN;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      S_SRCH: begin
        if (!sts_i.hold) begin
          if (sts_i.found || sts_i.idx_last) begin
            state_d = S_FIN;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      S_SVC: begin
        if (!sts_i.hold) begin
          if (sts_i.idx_last) begin
            state_d = S_FIN;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      S_EXEC: state_d = S_FIN;
      S_FIN: begin
        if (!sts_i.hold) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/mspt_datapath.sv =====
// Datapath of the multi-slot periodic timer: slot store, clock, result staging.
module mspt_datapath #(
  parameter int NUM_SLOTS = mspt_pkg::DEF_NUM_SLOTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mspt_pkg::in_item_t  in_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output mspt_pkg::out_item_t out_o,
  input  mspt_pkg::ctrl_cmd_t cmd_i,
  output mspt_pkg::ctrl_sts_t sts_o
);
  import mspt_pkg::*;

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(NUM_SLOTS - 1);

  // captured item
  logic [2:0]  op_q;
  logic [2:0]  slot_q;
  logic [31:0] ival_q;
  logic        kbit_q;

  logic [31:0]     clock_q;
  logic [IdxW-1:0] idx_q;
  logic [1:0]      skind_q [NUM_SLOTS];
  logic [1:0]      srun_q  [NUM_SLOTS];

  logic [31:0] per_mem [NUM_SLOTS];
  logic [31:0] lf_mem  [NUM_SLOTS];
  logic [31:0] per_rd_q, lf_rd_q;

  logic        live_q, fire_q;
  logic [31:0] cand_q;

  logic             pend_valid_q;
  logic [2:0]       pend_code_q, pend_slot_q;
  logic [CNT_W-1:0] cnt_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic [IdxW-1:0] sidx;
  logic            slot_ok;
  logic [1:0]      cur_kind, cur_run;
  logic            found, svc_hit;
  logic [31:0]     elapsed, nlf;
  logic            gen, take, hold, out_free, push_mid, push_fin;
  logic [2:0]      gen_code, gen_slot;

  logic            per_we, lf_we;
  logic [IdxW-1:0] per_wa, lf_wa;
  logic [31:0]     per_wd, lf_wd;

  assign sidx     = IdxW'(slot_q);
  assign slot_ok  = int'(slot_q) < NUM_SLOTS;
  assign cur_kind = skind_q[idx_q];
  assign cur_run  = srun_q[idx_q];
  assign found    = (cur_kind == KIND_EMPTY);
  assign svc_hit  = (cur_kind == KIND_LOOP) && (cur_run == RUN_DUE);
  assign elapsed  = clock_q - lf_rd_q;
  assign nlf      = (cand_q > clock_q) ? clock_q : cand_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    gen      = 1'b0;
    gen_code = RES_DONE;
    gen_slot = 3'd0;
    if (cmd_i.wr && fire_q && (cur_kind == KIND_IRQ)) begin
      gen      = 1'b1;
      gen_code = RES_IRQ_DUE;
      gen_slot = 3'(idx_q);
    end
    if (cmd_i.srch) begin
      if (found) begin
        gen      = 1'b1;
        gen_code = RES_ASSIGNED;
        gen_slot = 3'(idx_q);
      end else if (idx_q == IdxLast) begin
        gen      = 1'b1;
        gen_code = RES_FULL;
      end
    end
    if (cmd_i.svc && svc_hit) begin
      gen      = 1'b1;
      gen_code = RES_LOOP_RUN;
      gen_slot = 3'(idx_q);
    end
  end

  // beyond the result cap a hit still updates state but emits nothing
  assign take     = gen && (cnt_q < CNT_W'(MAX_RESULTS));
  assign hold     = (take && pend_valid_q && !out_free) || (cmd_i.fin && !out_free);
  assign push_mid = take && pend_valid_q && !hold;
  assign push_fin = cmd_i.fin && !hold;

  assign sts_o.hold     = hold;
  assign sts_o.idx_last = (idx_q == IdxLast);
  assign sts_o.found    = found;
  assign sts_o.op       = in_i.opcode;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    per_we = 1'b0;
    per_wa = idx_q;
    per_wd = ival_q;
    lf_we  = 1'b0;
    lf_wa  = idx_q;
    lf_wd  = clock_q;
    if (cmd_i.wr && live_q && !hold) begin
      lf_we = 1'b1;
      lf_wd = nlf;
    end
    if (cmd_i.srch && found && !hold) begin
      per_we = 1'b1;
      lf_we  = 1'b1;
    end
    if (cmd_i.exec && slot_ok) begin
      if (op_q == OP_RESUME) begin
        lf_we = 1'b1;
        lf_wa = sidx;
      end
      if (op_q == OP_SET_IVAL) begin
        per_we = 1'b1;
        per_wa = sidx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (per_we) begin
      per_mem[per_wa] <= per_wd;
    end
    if (lf_we) begin
      lf_mem[lf_wa] <= lf_wd;
    end
    if (cmd_i.rd) begin
      per_rd_q <= per_mem[idx_q];
      lf_rd_q  <= lf_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_i.opcode;
      slot_q <= in_i.slot;
      ival_q <= in_i.interval;
      kbit_q <= in_i.kind;
    end
    if (cmd_i.ev) begin
      live_q <= (cur_kind != KIND_EMPTY) && (cur_run != RUN_STOPPED);
      fire_q <= (cur_kind != KIND_EMPTY) && (cur_run != RUN_STOPPED) &&
                (elapsed >= per_rd_q);
      cand_q <= (elapsed >= per_rd_q) ? (lf_rd_q + per_rd_q) : lf_rd_q;
    end
    if (push_mid) begin
      out_q.code      <= pend_code_q;
      out_q.slot_out  <= pend_slot_q;
      out_q.clock_now <= clock_q;
      out_q.last      <= 1'b0;
    end else if (push_fin) begin
      out_q.code      <= pend_valid_q ? pend_code_q : RES_DONE;
      out_q.slot_out  <= pend_valid_q ? pend_slot_q : 3'd0;
      out_q.clock_now <= clock_q;
      out_q.last      <= 1'b1;
    end
    if (take && !hold) begin
      pend_code_q <= gen_code;
      pend_slot_q <= gen_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q      <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        skind_q[i] <= KIND_EMPTY;
        srun_q[i]  <= RUN_STOPPED;
      end
    end else begin
      if (cmd_i.capture) begin
        idx_q <= '0;
        if (in_i.opcode == OP_TICK) begin
          clock_q <= clock_q + in_i.tick_amount;
        end
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end

      if (cmd_i.capture || push_fin) begin
        pend_valid_q <= 1'b0;
        cnt_q        <= '0;
      end else if (take && !hold) begin
        pend_valid_q <= 1'b1;
        cnt_q        <= CNT_W'(cnt_q + 1'b1);
      end

      if (push_mid || push_fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.wr && fire_q && !hold) begin
        srun_q[idx_q] <= RUN_DUE;
      end
      if (cmd_i.srch && found && !hold) begin
        skind_q[idx_q] <= kbit_q ? KIND_LOOP : KIND_IRQ;
        srun_q[idx_q]  <= RUN_RUNNING;
      end
      if (cmd_i.svc && svc_hit && !hold) begin
        srun_q[idx_q] <= RUN_RUNNING;
      end
      if (cmd_i.exec && slot_ok) begin
        case (op_q)
          OP_REMOVE: begin
            skind_q[sidx] <= KIND_EMPTY;
            srun_q[sidx]  <= RUN_STOPPED;
          end
          OP_PAUSE:  srun_q[sidx] <= RUN_STOPPED;
          OP_RESUME: srun_q[sidx] <= RUN_RUNNING;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture && (in_i.opcode == OP_TICK) |=>
      clock_q == $past(clock_q) + $past(in_i.tick_amount))
    else $error("clock did not advance by the tick amount");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("result count above cap");
  a_pend_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (cnt_q != '0))
    else $error("pending result without count");
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fin |=> out_valid_q && out_q.last)
    else $error("final transfer not marked last");
`endif

endmodule

// ===== design/multi_slot_periodic_timer_core.sv =====
// Flow: tick walks every slot, add stops at the first empty slot, service walks every slot,
//   slot commands run one step, a spare opcode none, then the final result is loaded out.
// Throughput: one item at a time; the next item is taken once the final result is staged.
//   The rate is set by the per-slot walk (read, evaluate, write back).
// Reset: asynchronous, active low; all slots empty and stopped, clock zero, no clearing pass.
module multi_slot_periodic_timer_core #(
  parameter int NUM_SLOTS = mspt_pkg::DEF_NUM_SLOTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mspt_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mspt_pkg::out_item_t out_o
);
  import mspt_pkg::*;

  // Command and status between the sequencer and the datapath.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer: hold off input transfers while an item is at work; walk the
  // slots one at a time for tick (three phases per slot), add and service,
  // then stage the final result.
  mspt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: slot kinds and run states in flops, interval and last-fire
  // time in memories with registered reads. Each result is held back one
  // step so the last one of an item can be flagged; a stalled output
  // register pauses the walk only when a new result must move out.
  mspt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
